// ===== rtl/core/stt_pkg.sv =====
// Shared types, constants and arithmetic helpers of the steer-toward-target block.
package stt_pkg;

   localparam int REQ_W = 200;
   localparam int RSP_W = 32;

   localparam logic [1:0] CSR_SLOW_RADIUS      = 2'd0;
   localparam logic [1:0] CSR_FULL_STEER_ANGLE = 2'd1;
   localparam logic [1:0] CSR_MIN_THROTTLE     = 2'd2;

   localparam logic [30:0] SLOW_RADIUS_RST      = 31'd983040;
   localparam logic [15:0] FULL_STEER_ANGLE_RST = 16'd8579;
   localparam logic [14:0] MIN_THROTTLE_RST     = 15'd4096;

   localparam logic [14:0] ONE_Q14 = 15'd16384;
   localparam logic [32:0] MIN_DIST_Q16 = 33'd655;
   localparam logic [20:0] MIN_DIST_SQ = 21'(MIN_DIST_Q16) * 21'(MIN_DIST_Q16);
   localparam logic [33:0] MIN_FWD_Q28 = 34'd2684355;
   localparam logic [44:0] MIN_FWD_SQ = 45'(MIN_FWD_Q28) * 45'(MIN_FWD_Q28);
   localparam logic signed [27:0] PI_Q24 = 28'sd52707179;
   localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;
   localparam int SQRT_STEPS = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int DIV_STEPS = 15;

   typedef struct packed {
      logic slow_radius_pad;
      logic [30:0] slow_radius;
      logic [15:0] full_steer_angle;
      logic [14:0] min_throttle;
   } stt_cfg_type;

   typedef struct packed {
      logic cmd;
      logic dshift;
      logic [30:0] ux_h;
      logic [30:0] uz_h;
      logic signed [19:0] upy14;
      logic signed [20:0] tx;
      logic signed [20:0] tz;
      logic signed [20:0] gx;
      logic signed [20:0] gz;
   } stt_item_type;

   function automatic logic [6:0] msb_index(input logic [63:0] v);
      logic [6:0] h;
      h = '0;
      for (int k = 0; k < 64; k++) begin
         if (v[k]) h = 7'(k);
      end
      return h;
   endfunction

   // Smallest right shift that brings m below 2**bits.
   function automatic logic [5:0] fit_shift(input logic [63:0] m, input int bits);
      logic [6:0] h;
      h = msb_index(m);
      if ((m >> bits) != 64'd0) return 6'(h - 7'(bits) + 7'd1);
      return 6'd0;
   endfunction

   // Right shift of the magnitude, rounding toward zero.
   function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
                                                 input logic [5:0] s);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = m >> s;
      return v[63] ? $signed(-m) : $signed(m);
   endfunction

   function automatic logic signed [27:0] cordic_angle(input int i);
      case (i)
         0: return 28'sd13176795;
         1: return 28'sd7778716;
         2: return 28'sd4110060;
         3: return 28'sd2086331;
         4: return 28'sd1047214;
         5: return 28'sd524117;
         6: return 28'sd262123;
         7: return 28'sd131069;
         default: return 28'sd1 <<< (24 - i);
      endcase
   endfunction

endpackage

// ===== rtl/core/stt_queue.sv =====
// Small item queue between the classifying front end and the execution back end.
module stt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  stt_pkg::stt_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output stt_pkg::stt_item_type out_item
);
   import stt_pkg::*;

   stt_item_type mem_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QUEUE_AW:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_item = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= in_item;
   end

endmodule

// ===== rtl/core/stt_front.sv =====
// Front end: unpacks an item, forms offsets and axis terms, and flags short vectors and items not marked ready.
module stt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [stt_pkg::REQ_W-1:0]  in_data,
   output logic                       item_valid,
   input  logic                       item_ready,
   output stt_pkg::stt_item_type      item
);
   import stt_pkg::*;

   logic fen;
   logic v1_ff, v2_ff, v3_ff;

   logic rdy1_ff;
   logic signed [32:0] dx1_ff, dz1_ff, dx_in, dz_in;
   logic signed [31:0] pwy_ff, pxz_ff, pxx_ff, pyy_ff, pzz_ff;
   logic signed [31:0] pwy_in, pxz_in, pxx_in, pyy_in, pzz_in;
   logic signed [15:0] qw, qx, qy, qz;

   logic cmd2_ff, cmd2_in, dsh2_ff, dsh2_in;
   logic [30:0] uxh2_ff, uzh2_ff, uxh_in, uzh_in;
   logic signed [20:0] tx2_ff, tz2_ff, tx_in, tz_in;
   logic signed [33:0] fx2_ff, fz2_ff, fx_in, fz_in, upy_in;
   logic signed [19:0] upy2_ff, upy14_in;
   logic [32:0] ux, uz;
   logic [20:0] dsq;
   logic [5:0] dfs;

   stt_item_type item_ff, item_in;
   logic [33:0] ufx, ufz;
   logic [44:0] fsq;
   logic [5:0] ffs;

   assign fen = !v3_ff || item_ready;
   assign in_ready = fen;
   assign item_valid = v3_ff;
   assign item = item_ff;

   assign qw = $signed(in_data[144:129]);
   assign qx = $signed(in_data[160:145]);
   assign qy = $signed(in_data[176:161]);
   assign qz = $signed(in_data[192:177]);

   always_comb begin
      dx_in  = 33'($signed(in_data[96:65])) - 33'($signed(in_data[32:1]));
      dz_in  = 33'($signed(in_data[128:97])) - 33'($signed(in_data[64:33]));
      pwy_in = 32'(qw) * 32'(qy);
      pxz_in = 32'(qx) * 32'(qz);
      pxx_in = 32'(qx) * 32'(qx);
      pyy_in = 32'(qy) * 32'(qy);
      pzz_in = 32'(qz) * 32'(qz);
   end

   always_comb begin
      ux = dx1_ff[32] ? 33'(-dx1_ff) : 33'(dx1_ff);
      uz = dz1_ff[32] ? 33'(-dz1_ff) : 33'(dz1_ff);
      fx_in  = (34'(pwy_ff) + 34'(pxz_ff)) <<< 1;
      fz_in  = ONE_Q28 - ((34'(pxx_ff) + 34'(pyy_ff)) <<< 1);
      upy_in = ONE_Q28 - ((34'(pxx_ff) + 34'(pzz_ff)) <<< 1);
      upy14_in = 20'(shr_tz(64'(upy_in), 6'd14));
      dsq = 21'(ux[9:0]) * 21'(ux[9:0]) + 21'(uz[9:0]) * 21'(uz[9:0]);
      cmd2_in = rdy1_ff &&
                !(ux < MIN_DIST_Q16 && uz < MIN_DIST_Q16 && dsq < MIN_DIST_SQ);
      dsh2_in = (ux[32:31] != 2'b00) || (uz[32:31] != 2'b00);
      uxh_in = dsh2_in ? ux[31:1] : ux[30:0];
      uzh_in = dsh2_in ? uz[31:1] : uz[30:0];
      dfs = fit_shift(64'(ux | uz), 20);
      tx_in = 21'(shr_tz(64'(dx1_ff), dfs));
      tz_in = 21'(shr_tz(64'(dz1_ff), dfs));
   end

   always_comb begin
      ufx = fx2_ff[33] ? 34'(-fx2_ff) : 34'(fx2_ff);
      ufz = fz2_ff[33] ? 34'(-fz2_ff) : 34'(fz2_ff);
      fsq = 45'(ufx[21:0]) * 45'(ufx[21:0]) + 45'(ufz[21:0]) * 45'(ufz[21:0]);
      ffs = fit_shift(64'(ufx | ufz), 20);
      item_in.cmd = cmd2_ff &&
                    !(ufx < MIN_FWD_Q28 && ufz < MIN_FWD_Q28 && fsq < MIN_FWD_SQ);
      item_in.dshift = dsh2_ff;
      item_in.ux_h = uxh2_ff;
      item_in.uz_h = uzh2_ff;
      item_in.upy14 = upy2_ff;
      item_in.tx = tx2_ff;
      item_in.tz = tz2_ff;
      item_in.gx = 21'(shr_tz(64'(fx2_ff), ffs));
      item_in.gz = 21'(shr_tz(64'(fz2_ff), ffs));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (fen) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         rdy1_ff <= in_data[0];
         dx1_ff  <= dx_in;
         dz1_ff  <= dz_in;
         pwy_ff  <= pwy_in;
         pxz_ff  <= pxz_in;
         pxx_ff  <= pxx_in;
         pyy_ff  <= pyy_in;
         pzz_ff  <= pzz_in;
         cmd2_ff <= cmd2_in;
         dsh2_ff <= dsh2_in;
         uxh2_ff <= uxh_in;
         uzh2_ff <= uzh_in;
         tx2_ff  <= tx_in;
         tz2_ff  <= tz_in;
         fx2_ff  <= fx_in;
         fz2_ff  <= fz_in;
         upy2_ff <= upy14_in;
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/core/stt_div.sv =====
// Pipelined restoring divider giving a quotient saturated at one in Q1.14.
module stt_div (
   input  logic        clock,
   input  logic        enable,
   input  logic [46:0] num,
   input  logic [30:0] den,
   output logic [14:0] quot
);
   import stt_pkg::*;

   logic [46:0] rem_ff [0:DIV_STEPS-1];
   logic [14:0] q_ff [0:DIV_STEPS-1];
   logic sat_ff [0:DIV_STEPS-1];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BITPOS = DIV_STEPS - 1 - k;
      logic [46:0] rem_prev, dsh, rem_in;
      logic [14:0] q_prev, q_in;
      logic sat_prev;
      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign q_prev = '0;
         assign sat_prev = num >= (47'(den) << DIV_STEPS);
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign sat_prev = sat_ff[k-1];
      end
      assign dsh = 47'(den) << BITPOS;
      always_comb begin
         rem_in = rem_prev;
         q_in = q_prev;
         if (rem_prev >= dsh) begin
            rem_in = rem_prev - dsh;
            q_in[BITPOS] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            q_ff[k] <= q_in;
            sat_ff[k] <= sat_prev;
         end
      end
   end

   assign quot = (sat_ff[DIV_STEPS-1] || q_ff[DIV_STEPS-1] > ONE_Q14) ?
                 ONE_Q14 : q_ff[DIV_STEPS-1];

endmodule

// ===== rtl/core/stt_back.sv =====
// Back end: distance root, CORDIC heading angle, scaling divides and command output.
module stt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  stt_pkg::stt_item_type item,
   input  stt_pkg::stt_cfg_type  cfg,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_cmd,
   output logic [14:0]           rsp_throttle,
   output logic signed [15:0]    rsp_steer
);
   import stt_pkg::*;

   localparam int SQ_END = SQRT_STEPS;
   localparam int CR_END = 2 + CORDIC_STEPS;
   localparam int DV_END = SQ_END + DIV_STEPS;
   localparam int OUT_IDX = DV_END + 1;

   logic ben;
   logic vld_ff [0:OUT_IDX];
   logic cmd_ff [0:OUT_IDX];

   logic [62:0] v_ff [0:SQ_END];
   logic [63:0] r_ff [0:SQ_END];
   logic dsh_ff [0:SQ_END];

   logic signed [41:0] c_ff, d_ff, c_in, d_in;
   logic signed [19:0] upy_ff;
   logic [62:0] sq_in;
   logic signed [61:0] yv_ff, xv_ff, yv_in, xv_in;

   logic signed [33:0] x_ff [2:CR_END];
   logic signed [33:0] y_ff [2:CR_END];
   logic signed [27:0] z_ff [2:CR_END];
   logic zr_ff [2:CR_END];
   logic signed [27:0] ang_ff [CR_END+1:SQ_END];

   logic [61:0] mx, my;
   logic [5:0] ns;
   logic signed [33:0] xn, yn, x0_in, y0_in;
   logic signed [27:0] z0_in;

   logic [32:0] range_q16;
   logic [26:0] ang_mag;
   logic [46:0] num_thr, num_str;
   logic [14:0] q_thr, q_str;
   logic neg_ff [SQ_END+1:DV_END];
   logic zero_ff [SQ_END+1:DV_END];

   logic [14:0] thr_ff, thr_in, smag;
   logic signed [15:0] steer_ff, steer_in;

   assign ben = !vld_ff[OUT_IDX] || rsp_ready;
   assign item_ready = ben;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= OUT_IDX; k++) vld_ff[k] <= 1'b0;
      end else if (ben) begin
         vld_ff[0] <= item_valid;
         for (int k = 1; k <= OUT_IDX; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_comb begin
      sq_in = 63'(item.ux_h) * 63'(item.ux_h) + 63'(item.uz_h) * 63'(item.uz_h);
      c_in = 42'(item.tz) * 42'(item.gx) - 42'(item.tx) * 42'(item.gz);
      d_in = 42'(item.tx) * 42'(item.gx) + 42'(item.tz) * 42'(item.gz);
      yv_in = 62'(upy_ff) * 62'(c_ff);
      xv_in = 62'(d_ff) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         for (int k = 1; k <= OUT_IDX; k++) cmd_ff[k] <= cmd_ff[k-1];
         cmd_ff[0] <= item.cmd;
         v_ff[0] <= sq_in;
         r_ff[0] <= '0;
         dsh_ff[0] <= item.dshift;
         for (int k = 1; k <= SQ_END; k++) dsh_ff[k] <= dsh_ff[k-1];
         c_ff <= c_in;
         d_ff <= d_in;
         upy_ff <= item.upy14;
         yv_ff <= yv_in;
         xv_ff <= xv_in;
      end
   end

   for (genvar k = 1; k <= SQ_END; k++) begin : g_sqrt
      localparam logic [63:0] BITV = 64'd1 << (62 - 2 * (k - 1));
      logic [63:0] trial, r_in;
      logic [62:0] v_in;
      assign trial = r_ff[k-1] + BITV;
      always_comb begin
         if ({1'b0, v_ff[k-1]} >= trial) begin
            v_in = v_ff[k-1] - trial[62:0];
            r_in = (r_ff[k-1] >> 1) + BITV;
         end else begin
            v_in = v_ff[k-1];
            r_in = r_ff[k-1] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (ben) begin
            v_ff[k] <= v_in;
            r_ff[k] <= r_in;
         end
      end
   end

   always_comb begin
      mx = xv_ff[61] ? 62'(-xv_ff) : 62'(xv_ff);
      my = yv_ff[61] ? 62'(-yv_ff) : 62'(yv_ff);
      ns = fit_shift(64'(mx | my), 30);
      xn = 34'(shr_tz(64'(xv_ff), ns));
      yn = 34'(shr_tz(64'(yv_ff), ns));
      x0_in = xn;
      y0_in = yn;
      z0_in = '0;
      if (xn < 0) begin
         z0_in = (yn >= 0) ? PI_Q24 : -PI_Q24;
         x0_in = -xn;
         y0_in = -yn;
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         x_ff[2] <= x0_in;
         y_ff[2] <= y0_in;
         z_ff[2] <= z0_in;
         zr_ff[2] <= (xv_ff == '0) && (yv_ff == '0);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [27:0] ANGLE = cordic_angle(i);
      logic signed [33:0] xs, ys, x_in, y_in;
      logic signed [27:0] z_in;
      assign xs = 34'(shr_tz(64'(x_ff[2+i]), 6'(i)));
      assign ys = 34'(shr_tz(64'(y_ff[2+i]), 6'(i)));
      always_comb begin
         if (y_ff[2+i] > 0) begin
            x_in = x_ff[2+i] + ys;
            y_in = y_ff[2+i] - xs;
            z_in = z_ff[2+i] + ANGLE;
         end else begin
            x_in = x_ff[2+i] - ys;
            y_in = y_ff[2+i] + xs;
            z_in = z_ff[2+i] - ANGLE;
         end
      end
      always_ff @(posedge clock) begin
         if (ben) begin
            x_ff[3+i] <= x_in;
            y_ff[3+i] <= y_in;
            z_ff[3+i] <= z_in;
            zr_ff[3+i] <= zr_ff[2+i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         ang_ff[CR_END+1] <= zr_ff[CR_END] ? 28'sd0 : z_ff[CR_END];
         for (int k = CR_END + 2; k <= SQ_END; k++) ang_ff[k] <= ang_ff[k-1];
      end
   end

   always_comb begin
      range_q16 = 33'(r_ff[SQ_END][31:0]) << dsh_ff[SQ_END];
      num_thr = {range_q16, 14'd0};
      ang_mag = ang_ff[SQ_END][27] ? 27'(-ang_ff[SQ_END]) : 27'(ang_ff[SQ_END]);
      num_str = 47'({ang_mag, 4'd0});
   end

   stt_div u_div_thr (
      .clock  (clock),
      .enable (ben),
      .num    (num_thr),
      .den    (cfg.slow_radius),
      .quot   (q_thr)
   );

   stt_div u_div_str (
      .clock  (clock),
      .enable (ben),
      .num    (num_str),
      .den    (31'(cfg.full_steer_angle)),
      .quot   (q_str)
   );

   always_ff @(posedge clock) begin
      if (ben) begin
         neg_ff[SQ_END+1] <= ang_ff[SQ_END][27];
         zero_ff[SQ_END+1] <= ang_ff[SQ_END] == '0;
         for (int k = SQ_END + 2; k <= DV_END; k++) begin
            neg_ff[k] <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   always_comb begin
      thr_in = (q_thr < cfg.min_throttle) ? cfg.min_throttle : q_thr;
      if (thr_in > ONE_Q14) thr_in = ONE_Q14;
      smag = zero_ff[DV_END] ? 15'd0 : q_str;
      steer_in = neg_ff[DV_END] ? -16'(smag) : 16'(smag);
      if (!cmd_ff[DV_END]) begin
         thr_in = '0;
         steer_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ben) begin
         thr_ff <= thr_in;
         steer_ff <= steer_in;
      end
   end

   assign rsp_valid = vld_ff[OUT_IDX];
   assign rsp_cmd = cmd_ff[OUT_IDX];
   assign rsp_throttle = thr_ff;
   assign rsp_steer = steer_ff;

endmodule

// ===== rtl/core/steer_toward_target.sv =====
// Top level of the steer-toward-target block: control registers and the front and back ends.
//
// One vehicle item enters on the req_ channel and one drive command leaves on the
// rsp_ channel for every item, in order. A front end of three stages forms the
// ground offsets and axis terms and flags items that give no command; a four-entry
// queue decouples it from the back end. The back end is a 49-stage pipeline: a
// 32-stage square root for the distance runs beside a 24-stage CORDIC for the
// heading angle, and two 15-stage dividers scale throttle and steer.
// With no stall one item is taken every cycle. When rsp_tready is low the back end
// holds, the queue fills and then req_tready falls; nothing is lost or repeated.
// Reset empties all stages and the queue and loads the control registers with their
// defaults (slow radius 15.0, full steer angle 30 degrees, minimum throttle 0.25).
// Control registers are written through csr_wen, csr_index and csr_wdata; the user
// must write them only while no item is in flight, which the block does not enforce.
module steer_toward_target (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // vehicle_ready, pos_x, pos_z, target_x, target_z, quat_w, quat_x, quat_y, quat_z
   input  logic [stt_pkg::REQ_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // command_issued, throttle_out, steer_out
   output logic [stt_pkg::RSP_W-1:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import stt_pkg::*;

   stt_cfg_type cfg_ff, cfg_in;
   logic f_valid, f_ready, q_valid, q_ready;
   stt_item_type f_item, q_item;
   logic rsp_cmd;
   logic [14:0] rsp_throttle;
   logic signed [15:0] rsp_steer;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_SLOW_RADIUS:      cfg_in.slow_radius = csr_wdata;
            CSR_FULL_STEER_ANGLE: cfg_in.full_steer_angle = csr_wdata[15:0];
            CSR_MIN_THROTTLE:     cfg_in.min_throttle = csr_wdata[14:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_radius_pad  <= 1'b0;
         cfg_ff.slow_radius      <= SLOW_RADIUS_RST;
         cfg_ff.full_steer_angle <= FULL_STEER_ANGLE_RST;
         cfg_ff.min_throttle     <= MIN_THROTTLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_data    (req_tdata),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item       (f_item)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   stt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (q_valid),
      .item_ready   (q_ready),
      .item         (q_item),
      .cfg          (cfg_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_cmd      (rsp_cmd),
      .rsp_throttle (rsp_throttle),
      .rsp_steer    (rsp_steer)
   );

   assign rsp_tdata = {rsp_steer, rsp_throttle, rsp_cmd};

endmodule

// ===== bench/steer_toward_target_check.sv =====
// Checker for the steer-toward-target block: predicts every drive command and compares.
`timescale 1ns / 1ps

module steer_toward_target_check (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [stt_pkg::REQ_W-1:0] req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [stt_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                     csr_wen,
   input  logic [1:0]               csr_index,
   input  logic [30:0]              csr_wdata,
   output int                       errors,
   output int                       pending,
   output int                       commands
);
   import stt_pkg::*;

   localparam longint Q14 = 16384;
   localparam longint DIST_MIN = 655;
   localparam longint FWD_MIN = 2684355;
   localparam longint PI24 = 52707179;

   // Laid out as on rsp_tdata: the issued flag in the lowest bit.
   typedef struct packed {
      logic signed [15:0] steer;
      logic [14:0] throttle;
      logic        issued;
   } drive_cmd_type;

   drive_cmd_type cmd_queue[$];
   logic [30:0] radius_q16;
   logic [15:0] lock_angle;
   logic [14:0] floor_thr;

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint shift_toward_zero(longint v, int s);
      return v < 0 ? -((-v) >> s) : (v >> s);
   endfunction

   function automatic int shift_to_fit(longint a, longint b, int bits);
      longint m;
      int s;
      m = abs64(a) | abs64(b);
      s = 0;
      while (s < 63 && (m >> s) >= (64'sd1 << bits)) s++;
      return s;
   endfunction

   function automatic longint int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint heading_q24(longint y, longint x);
      longint z, xs, ys, a;
      int s;
      z = 0;
      if (x == 0 && y == 0) return 0;
      s = shift_to_fit(x, y, 30);
      x = shift_toward_zero(x, s);
      y = shift_toward_zero(y, s);
      if (x < 0) begin
         z = (y >= 0) ? PI24 : -PI24;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 24; i++) begin
         a = longint'(cordic_angle(i));
         xs = shift_toward_zero(x, i);
         ys = shift_toward_zero(y, i);
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + a;
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - a;
         end
      end
      return z;
   endfunction

   function automatic drive_cmd_type steer_command(logic [stt_pkg::REQ_W-1:0] d);
      drive_cmd_type r;
      longint dx, dz, qw, qx, qy, qz, fx, fz, upy, ux, uz, ufx, ufz;
      longint dist_q16, thr, tx, tz, gx, gz, c, dp, ang, steer;
      int s;
      r = '0;
      dx = longint'($signed(d[96:65])) - longint'($signed(d[32:1]));
      dz = longint'($signed(d[128:97])) - longint'($signed(d[64:33]));
      qw = longint'($signed(d[144:129]));
      qx = longint'($signed(d[160:145]));
      qy = longint'($signed(d[176:161]));
      qz = longint'($signed(d[192:177]));
      fx = 2 * (qw * qy + qx * qz);
      fz = (64'sd1 << 28) - 2 * (qx * qx + qy * qy);
      upy = (64'sd1 << 28) - 2 * (qx * qx + qz * qz);
      ux = abs64(dx);
      uz = abs64(dz);
      ufx = abs64(fx);
      ufz = abs64(fz);
      if (!d[0]) return r;
      if (ux < DIST_MIN && uz < DIST_MIN && ux * ux + uz * uz < DIST_MIN * DIST_MIN)
         return r;
      if (ufx < FWD_MIN && ufz < FWD_MIN && ufx * ufx + ufz * ufz < FWD_MIN * FWD_MIN)
         return r;
      s = ((ux | uz) >> 31) != 0 ? 1 : 0;
      dist_q16 = int_sqrt(64'((ux >> s) * (ux >> s) + (uz >> s) * (uz >> s))) << s;
      if (radius_q16 == 0) thr = Q14;
      else thr = dist_q16 * Q14 / longint'(radius_q16);
      if (thr < longint'(floor_thr)) thr = longint'(floor_thr);
      if (thr > Q14) thr = Q14;
      s = shift_to_fit(dx, dz, 20);
      tx = shift_toward_zero(dx, s);
      tz = shift_toward_zero(dz, s);
      s = shift_to_fit(fx, fz, 20);
      gx = shift_toward_zero(fx, s);
      gz = shift_toward_zero(fz, s);
      c = tz * gx - tx * gz;
      dp = tx * gx + tz * gz;
      ang = heading_q24(shift_toward_zero(upy, 14) * c, dp * Q14);
      if (lock_angle == 0) steer = ang > 0 ? Q14 : (ang < 0 ? -Q14 : 0);
      else steer = (ang * Q14) / (longint'(lock_angle) * 1024);
      if (steer > Q14) steer = Q14;
      if (steer < -Q14) steer = -Q14;
      r.issued = 1'b1;
      r.throttle = thr[14:0];
      r.steer = steer[15:0];
      return r;
   endfunction

   assign pending = cmd_queue.size();

   always @(posedge clock) begin
      drive_cmd_type want, got;
      if (reset) begin
         radius_q16 <= SLOW_RADIUS_RST;
         lock_angle <= FULL_STEER_ANGLE_RST;
         floor_thr <= MIN_THROTTLE_RST;
         cmd_queue.delete();
         errors <= 0;
         commands <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_SLOW_RADIUS: radius_q16 <= csr_wdata;
               CSR_FULL_STEER_ANGLE: lock_angle <= csr_wdata[15:0];
               CSR_MIN_THROTTLE: floor_thr <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) cmd_queue.push_back(steer_command(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (cmd_queue.size() == 0) begin
               $error("command_issued: unexpected item, actual %0d", got.issued);
               errors <= errors + 1;
            end else begin
               want = cmd_queue.pop_front();
               if (got.issued) commands <= commands + 1;
               if (got.issued !== want.issued) begin
                  $error("command_issued: expected %0d, actual %0d", want.issued, got.issued);
                  errors <= errors + 1;
               end else if (got.throttle !== want.throttle) begin
                  $error("throttle_out: expected %0d, actual %0d",
                         want.throttle, got.throttle);
                  errors <= errors + 1;
               end else if (got.steer !== want.steer) begin
                  $error("steer_out: expected %0d, actual %0d", want.steer, got.steer);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

// ===== bench/steer_toward_target_test.sv =====
// Top of the steer-toward-target testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module steer_toward_target_test;
   import stt_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_wen = 0;
   logic [1:0] csr_index = CSR_SLOW_RADIUS;
   logic [30:0] csr_wdata = '0;
   int errors, pending, commands;
   int idle_pct = 0, stall_pct = 0, quiet = 0, items = 0;

   steer_toward_target uut (.*);
   steer_toward_target_check checker_i (.*);

   always #1 clock = ~clock;

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_vehicle(logic rdy, logic [31:0] px, logic [31:0] pz,
                               logic [31:0] tx, logic [31:0] tz, logic [15:0] qw,
                               logic [15:0] qx, logic [15:0] qy, logic [15:0] qz);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, qz, qy, qx, qw, tz, tx, pz, px, rdy};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [30:0] val);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 0;
      @(posedge clock);
   endtask

   task automatic random_vehicle();
      logic [31:0] px, pz, tx, tz;
      logic [15:0] qw, qx, qy, qz;
      real a;
      int k;
      px = $urandom;
      pz = $urandom;
      k = $urandom_range(9);
      if (k < 5) begin
         tx = px + 32'($signed(20'($urandom)) * ($urandom_range(1) ? 64 : 1));
         tz = pz + 32'($signed(20'($urandom)) * ($urandom_range(1) ? 64 : 1));
      end else if (k < 7) begin
         tx = px + 32'($signed(11'($urandom)));
         tz = pz + 32'($signed(11'($urandom)));
      end else begin
         tx = $urandom;
         tz = $urandom;
      end
      k = $urandom_range(9);
      if (k < 6) begin
         a = ($urandom_range(62831) / 10000.0) - 3.14159;
         qw = 16'($rtoi(16384.0 * $cos(a / 2.0)));
         qy = 16'($rtoi(16384.0 * $sin(a / 2.0)));
         qx = 16'($signed(9'($urandom)));
         qz = 16'($signed(9'($urandom)));
      end else if (k < 8) begin
         qw = 16'($signed(15'($urandom)));
         qx = 16'($signed(15'($urandom)));
         qy = 16'($signed(15'($urandom)));
         qz = 16'($signed(15'($urandom)));
      end else begin
         qw = 16'($urandom);
         qx = 16'($urandom);
         qy = 16'($urandom);
         qz = 16'($urandom);
      end
      send_vehicle($urandom_range(9) != 0, px, pz, tx, tz, qw, qx, qy, qz);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Identity heading faces +z; a target straight behind gives an angle of pi.
      send_vehicle(0, 0, 0, 32'h00100000, 32'h00100000, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 0, 0, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 654, 0, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 463, 463, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 655, 0, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 0, 32'hFFF00000, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 0, 32'h00050000, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 32'h00050000, 0, 16384, 0, 0, 0);
      send_vehicle(1, 0, 0, 32'hFFFB0000, 0, 16384, 0, 0, 0);
      send_vehicle(1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   16384, 0, 0, 0);
      send_vehicle(1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                   11585, 0, 11585, 0);
      send_vehicle(1, 0, 0, 32'h00020000, 32'h00030000, 0, 8192, 8192, 0);
      send_vehicle(1, 0, 0, 32'h00020000, 32'h00030000, 0, 16384, 0, 0);
      send_vehicle(1, 0, 0, 32'h00020000, 32'h00030000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000);
      send_vehicle(1, 0, 0, 32'h00020000, 32'hFFFD0000, 16'h7FFF, 16'h7FFF,
                   16'h7FFF, 16'h7FFF);
      send_vehicle(1, 0, 0, 32'h00020000, 32'h00030000, 16'hC000, 16384, 16'hC000,
                   16384);
      send_vehicle(1, 0, 0, 32'h00100000, 32'h00100000, 16384, 0, 16384, 0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               write_csr(CSR_SLOW_RADIUS, 31'd1);
               write_csr(CSR_FULL_STEER_ANGLE, 31'd1);
               write_csr(CSR_MIN_THROTTLE, 31'd0);
            end
            2: begin
               write_csr(CSR_SLOW_RADIUS, 31'h7FFFFFFF);
               write_csr(CSR_FULL_STEER_ANGLE, 31'd51472);
               write_csr(CSR_MIN_THROTTLE, 31'd16384);
            end
            3: begin
               write_csr(CSR_SLOW_RADIUS, 31'd0);
               write_csr(CSR_FULL_STEER_ANGLE, 31'd0);
               write_csr(CSR_MIN_THROTTLE, 31'h7FFF);
            end
            4: begin
               write_csr(CSR_SLOW_RADIUS,
                         31'($urandom_range(32'h00400000, 32'h00010000)));
               write_csr(CSR_FULL_STEER_ANGLE, 31'hFFFF);
               write_csr(CSR_MIN_THROTTLE, 31'($urandom_range(16384)));
            end
            5: begin
               write_csr(CSR_SLOW_RADIUS, SLOW_RADIUS_RST);
               write_csr(CSR_FULL_STEER_ANGLE, 31'(FULL_STEER_ANGLE_RST));
               write_csr(CSR_MIN_THROTTLE, 31'(MIN_THROTTLE_RST));
            end
            default: ;
         endcase
         for (int mode = 0; mode < 4; mode++) begin
            idle_pct = (mode == 1 || mode == 3) ? (mode == 1 ? 58 : 29) : 0;
            stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 58 : 29) : 0;
            repeat (35) random_vehicle();
         end
         idle_pct = 0;
         stall_pct = 0;
         drain();
      end

      $display("Sent %0d vehicle items over six register settings and four idling modes;",
               items);
      $display("%0d of them produced a drive command.", commands);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_queue.sv
rtl/core/stt_front.sv
rtl/core/stt_div.sv
rtl/core/stt_back.sv
rtl/core/steer_toward_target.sv
bench/steer_toward_target_check.sv
bench/steer_toward_target_test.sv
